>>> design/rainbow_hue_led_encoder_unit_assert.svh
// assertion macros shared by the rainbow hue led encoder modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef RAINBOW_HUE_LED_ENCODER_UNIT_ASSERT_SVH
`define RAINBOW_HUE_LED_ENCODER_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define RHLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define RHLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rhle_pkg.sv
// shared types and constants of the rainbow hue led encoder
// no dependencies
package rhle_pkg;

  localparam int DutyW  = 10;
  localparam int IdxW   = 8;
  localparam int ColorW = 24;
  localparam int SlotW  = 5;
  localparam int HueW   = 11;
  localparam int StepW  = 11;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 11;

  localparam logic [HueW-1:0]  HueSpan  = 11'd1530;
  localparam logic [HueW:0]    HueSpan2 = 12'd3060;
  localparam logic [7:0]       RampMax  = 8'd255;
  localparam logic [SlotW-1:0] LastSlot = 5'd23;

  // register indexes on the config port
  localparam logic [CfgAddrW-1:0] CfgOneDuty  = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgZeroDuty = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgHueStep  = 2'd2;

  localparam logic [DutyW-1:0] OneDutyRst  = 10'd60;
  localparam logic [DutyW-1:0] ZeroDutyRst = 10'd30;
  localparam logic [StepW-1:0] HueStepRst  = 11'd8;

  // one led request after color resolution, color in g, r, b order
  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] grb;
  } rhle_item_t;

  typedef struct packed {
    logic [DutyW-1:0] one;
    logic [DutyW-1:0] zero;
  } rhle_duty_t;

endpackage

>>> design/rhle_fifo.sv
// small flop based queue of resolved led requests between front and back
// depends on rhle_pkg
module rhle_fifo import rhle_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rhle_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output rhle_item_t data_o,
  output logic       empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rhle_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`include "rainbow_hue_led_encoder_unit_assert.svh"

  `RHLE_ASSERT(a_fifo_count_bound, count_q <= FullCnt, "fifo count above depth")
  `RHLE_ASSERT_NEXT(a_fifo_push_fills, do_push, !empty_o, "fifo empty after push")
  `RHLE_ASSERT_NEXT(a_fifo_pop_drains, do_pop && !do_push,
    count_q == $past(count_q) - 1'b1, "fifo count not reduced by pop")

endmodule

>>> design/rhle_front.sv
// front end: takes led requests, drops out of range ones, resolves rainbow hue to color
// keeps the running hue offset; depends on rhle_pkg
module rhle_front import rhle_pkg::*; #(
  parameter int LedCount = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              mode_i,
  input  logic [IdxW-1:0]   led_index_i,
  input  logic [ColorW-1:0] rgb_color_i,
  output logic              full_o,
  input  logic [StepW-1:0]  hue_step_i,
  output logic              q_push_o,
  output rhle_item_t        q_item_o,
  input  logic              q_full_i
);

  localparam int ProdW      = 19;
  localparam int RecipShift = 27;
  localparam int RecipW     = 28;
  // idx*1530 stays below 2^19, so a 2^27 scaled reciprocal gives the exact quotient
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((1 << RecipShift) + LedCount - 1) / LedCount);
  localparam logic [IdxW-1:0] LedCountW = IdxW'(LedCount);
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(LedCount - 1);

  logic adv, accept;
  logic [HueW-1:0] offset_q, offset_d;
  logic [HueW:0]   off_sum;

  logic              va_q, vb_q, vc_q, vd_q;
  logic              mode_a_q, mode_b_q, mode_c_q, mode_d_q;
  logic [IdxW-1:0]   idx_a_q, idx_b_q, idx_c_q, idx_d_q;
  logic [ColorW-1:0] col_a_q, col_b_q, col_c_q, col_d_q;
  logic [HueW-1:0]   off_a_q, off_b_q, off_c_q;
  logic [ProdW-1:0]  prod_b_q;
  logic [HueW-1:0]   quot_c_q;
  logic [HueW-1:0]   hue_d_q, hue_d;
  logic [HueW:0]     hue_sum;
  logic [ProdW+RecipW-1:0] scaled;

  logic [HueW-1:0] ramp_base;
  logic [7:0]      ramp_v;
  logic [7:0]      r, g, b;

  // stall only when the last stage holds an item the queue cannot take
  assign adv      = !(vd_q && q_full_i);
  assign full_o   = !adv;
  assign accept   = push_i && adv;
  assign q_push_o = vd_q && !q_full_i;

  always_comb begin
    off_sum = {1'b0, offset_q} + {1'b0, hue_step_i};
    if (off_sum >= HueSpan2) begin
      off_sum = off_sum - HueSpan2;
    end else if (off_sum >= {1'b0, HueSpan}) begin
      off_sum = off_sum - {1'b0, HueSpan};
    end
    offset_d = offset_q;
    if (accept && mode_i && led_index_i == LastIdx) begin
      offset_d = off_sum[HueW-1:0];
    end
  end

  assign scaled  = (ProdW+RecipW)'(prod_b_q) * (ProdW+RecipW)'(Recip);
  assign hue_sum = {1'b0, quot_c_q} + {1'b0, off_c_q};
  assign hue_d   = (hue_sum >= {1'b0, HueSpan}) ? HueW'(hue_sum - {1'b0, HueSpan})
                                                : hue_sum[HueW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      vc_q     <= 1'b0;
      vd_q     <= 1'b0;
    end else begin
      offset_q <= offset_d;
      if (adv) begin
        va_q <= push_i && (led_index_i < LedCountW);
        vb_q <= va_q;
        vc_q <= vb_q;
        vd_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode_a_q <= mode_i;
      idx_a_q  <= led_index_i;
      col_a_q  <= rgb_color_i;
      off_a_q  <= offset_q;

      mode_b_q <= mode_a_q;
      idx_b_q  <= idx_a_q;
      col_b_q  <= col_a_q;
      off_b_q  <= off_a_q;
      prod_b_q <= ProdW'(idx_a_q) * ProdW'(HueSpan);

      mode_c_q <= mode_b_q;
      idx_c_q  <= idx_b_q;
      col_c_q  <= col_b_q;
      off_c_q  <= off_b_q;
      quot_c_q <= HueW'(scaled >> RecipShift);

      mode_d_q <= mode_c_q;
      idx_d_q  <= idx_c_q;
      col_d_q  <= col_c_q;
      hue_d_q  <= hue_d;
    end
  end

  // hue wheel: six ramps of 255 steps
  always_comb begin
    if (hue_d_q < 11'd255) begin
      ramp_base = 11'd0;
    end else if (hue_d_q < 11'd510) begin
      ramp_base = 11'd255;
    end else if (hue_d_q < 11'd765) begin
      ramp_base = 11'd510;
    end else if (hue_d_q < 11'd1020) begin
      ramp_base = 11'd765;
    end else if (hue_d_q < 11'd1275) begin
      ramp_base = 11'd1020;
    end else begin
      ramp_base = 11'd1275;
    end
    ramp_v = 8'(hue_d_q - ramp_base);

    case (ramp_base)
      11'd0: begin
        r = RampMax; g = ramp_v; b = 8'd0;
      end
      11'd255: begin
        r = RampMax - ramp_v; g = RampMax; b = 8'd0;
      end
      11'd510: begin
        r = 8'd0; g = RampMax; b = ramp_v;
      end
      11'd765: begin
        r = 8'd0; g = RampMax - ramp_v; b = RampMax;
      end
      11'd1020: begin
        r = ramp_v; g = 8'd0; b = RampMax;
      end
      default: begin
        r = RampMax; g = 8'd0; b = RampMax - ramp_v;
      end
    endcase

    if (!mode_d_q) begin
      r = col_d_q[23:16];
      g = col_d_q[15:8];
      b = col_d_q[7:0];
    end
  end

  assign q_item_o.idx = idx_d_q;
  assign q_item_o.grb = {g, r, b};

`include "rainbow_hue_led_encoder_unit_assert.svh"

  `RHLE_ASSERT(a_front_offset_range, offset_q < HueSpan, "hue offset out of range")
  `RHLE_ASSERT(a_front_hue_range, !vd_q || hue_d_q < HueSpan, "hue out of range")
  `RHLE_ASSERT_NEXT(a_front_stall_holds, vd_q && q_full_i,
    vd_q && $stable(hue_d_q) && $stable(idx_d_q), "stalled request lost")

endmodule

>>> design/rhle_back.sv
// back end: serializes one resolved color into 24 duty words, msb first, g r b
// depends on rhle_pkg
module rhle_back import rhle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  rhle_item_t       q_item_i,
  output logic             q_pop_o,
  input  rhle_duty_t       duty_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [DutyW-1:0] duty_o,
  output logic [IdxW-1:0]  out_index_o,
  output logic [SlotW-1:0] bit_slot_o,
  output logic             last_word_o
);

  logic                busy_q, busy_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [ColorW-1:0]   grb_q;
  logic [IdxW-1:0]     idx_q;
  logic                at_last, load;

  assign at_last = (slot_q == LastSlot);
  // refill on the pop of the last word so requests run back to back
  assign load    = !q_empty_i && (!busy_q || (pop_i && at_last));
  assign q_pop_o = load;

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (load) begin
      busy_d = 1'b1;
      slot_d = '0;
    end else if (busy_q && pop_i) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grb_q <= q_item_i.grb;
      idx_q <= q_item_i.idx;
    end
  end

  assign empty_o     = !busy_q;
  assign duty_o      = grb_q[LastSlot - slot_q] ? duty_i.one : duty_i.zero;
  assign out_index_o = idx_q;
  assign bit_slot_o  = slot_q;
  assign last_word_o = at_last;

`include "rainbow_hue_led_encoder_unit_assert.svh"

  `RHLE_ASSERT(a_back_slot_range, !busy_q || slot_q <= LastSlot, "bit slot out of range")
  `RHLE_ASSERT_NEXT(a_back_step, busy_q && pop_i && !at_last,
    busy_q && slot_q == $past(slot_q) + 1'b1 && $stable(grb_q), "word sequence broken")
  `RHLE_ASSERT_NEXT(a_back_hold, busy_q && !pop_i,
    busy_q && $stable(slot_q) && $stable(idx_q), "waiting word changed")

endmodule

>>> design/rainbow_hue_led_encoder_unit.sv
// rainbow hue led encoder: led request in, 24 pwm duty words out per led
// path: an accepted request passes front stages a to d, the queue and the serializer before its first word shows
// throughput: one word per cycle while pop is held, 24 words per led, from the serializer in the back end
// requests back to back; the front pipeline and queue run ahead while words drain
// reset clears the queue, the pipeline valids and the hue offset, and loads register defaults
// an index at or above the led count is taken and yields no words
module rainbow_hue_led_encoder_unit import rhle_pkg::*; #(
  parameter int LED_COUNT  = 80,
  parameter int FIFO_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic                mode_i,
  input  logic [IdxW-1:0]     led_index_i,
  input  logic [ColorW-1:0]   rgb_color_i,
  output logic                empty,
  input  logic                pop,
  output logic [DutyW-1:0]    duty_o,
  output logic [IdxW-1:0]     out_index_o,
  output logic [SlotW-1:0]    bit_slot_o,
  output logic                last_word_o
);

  rhle_duty_t       duty_q;
  logic [StepW-1:0] hue_step_q;

  logic       f_push, f_full, b_pop, b_empty;
  rhle_item_t f_item, b_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q.one  <= OneDutyRst;
      duty_q.zero <= ZeroDutyRst;
      hue_step_q  <= HueStepRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgOneDuty:  duty_q.one  <= cfg_wdata_i[DutyW-1:0];
        CfgZeroDuty: duty_q.zero <= cfg_wdata_i[DutyW-1:0];
        CfgHueStep:  hue_step_q  <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  rhle_front #(
    .LedCount(LED_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .mode_i      (mode_i),
    .led_index_i (led_index_i),
    .rgb_color_i (rgb_color_i),
    .full_o      (full),
    .hue_step_i  (hue_step_q),
    .q_push_o    (f_push),
    .q_item_o    (f_item),
    .q_full_i    (f_full)
  );

  rhle_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_item),
    .full_o  (f_full),
    .pop_i   (b_pop),
    .data_o  (b_item),
    .empty_o (b_empty)
  );

  rhle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (b_empty),
    .q_item_i    (b_item),
    .q_pop_o     (b_pop),
    .duty_i      (duty_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .duty_o      (duty_o),
    .out_index_o (out_index_o),
    .bit_slot_o  (bit_slot_o),
    .last_word_o (last_word_o)
  );

endmodule

>>> tb/sv/rhle_tb_pkg.sv
// word-level prediction and checking for the rainbow hue led encoder bench
// depends on rhle_pkg for widths, register indexes and register defaults
package rhle_tb_pkg;
  import rhle_pkg::*;

  localparam int          LedCount = 80;
  localparam int unsigned HueTurn  = 1530;
  localparam int unsigned RampTop  = 255;
  localparam int          WordsPerLed = 24;

  localparam logic ModeDirect  = 1'b0;
  localparam logic ModeRainbow = 1'b1;

  // index with no register behind it
  localparam logic [CfgAddrW-1:0] CfgSpare = 2'd3;

  typedef struct {
    logic [DutyW-1:0] duty;
    logic [IdxW-1:0]  idx;
    logic [SlotW-1:0] slot;
    logic             last;
  } led_word_t;

  class led_word_board;
    logic [DutyW-1:0] one_duty;
    logic [DutyW-1:0] zero_duty;
    logic [StepW-1:0] hue_step;
    int unsigned      frame_hue;
    led_word_t        pending[$];
    int               errors;

    function new();
      one_duty   = OneDutyRst;
      zero_duty  = ZeroDutyRst;
      hue_step   = HueStepRst;
      frame_hue  = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      case (addr)
        CfgOneDuty:  one_duty  = data[DutyW-1:0];
        CfgZeroDuty: zero_duty = data[DutyW-1:0];
        CfgHueStep:  hue_step  = data[StepW-1:0];
        default: ;
      endcase
    endfunction

    // six ramps of 255 steps around the wheel, result as r, g, b bytes
    function logic [ColorW-1:0] wheel_rgb(int unsigned hue);
      int unsigned h;
      int unsigned v;
      logic [7:0]  up;
      logic [7:0]  dn;
      logic [7:0]  top;
      h   = hue % HueTurn;
      v   = h % RampTop;
      up  = 8'(v);
      dn  = 8'(RampTop - v);
      top = 8'(RampTop);
      case (h / RampTop)
        0: return {top, up, 8'h00};
        1: return {dn, top, 8'h00};
        2: return {8'h00, top, up};
        3: return {8'h00, dn, top};
        4: return {up, 8'h00, top};
        default: return {top, 8'h00, dn};
      endcase
    endfunction

    function void note_request(logic mode, logic [IdxW-1:0] idx, logic [ColorW-1:0] color);
      logic [ColorW-1:0] rgb;
      logic [ColorW-1:0] grb;
      led_word_t         w;
      if (int'(idx) >= LedCount) return;
      rgb = color;
      if (mode == ModeRainbow)
        rgb = wheel_rgb((int'(idx) * HueTurn) / LedCount + frame_hue);
      grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
      for (int k = 0; k < WordsPerLed; k++) begin
        w.duty = grb[WordsPerLed-1-k] ? one_duty : zero_duty;
        w.idx  = idx;
        w.slot = SlotW'(k);
        w.last = (k == WordsPerLed - 1);
        pending.push_back(w);
      end
      // a rainbow request for the last led closes the frame
      if (mode == ModeRainbow && int'(idx) == LedCount - 1)
        frame_hue = (frame_hue + hue_step) % HueTurn;
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic [DutyW-1:0] duty, logic [IdxW-1:0] idx, logic [SlotW-1:0] slot,
                    logic last);
      led_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("word idx %0d slot %0d with no request waiting", idx, slot));
        return;
      end
      w = pending.pop_front();
      if (duty !== w.duty)
        report($sformatf("idx %0d slot %0d duty %0d, wanted %0d", w.idx, w.slot, duty, w.duty));
      if (idx !== w.idx)
        report($sformatf("idx %0d slot %0d out_index %0d", w.idx, w.slot, idx));
      if (slot !== w.slot)
        report($sformatf("idx %0d slot %0d bit_slot %0d", w.idx, w.slot, slot));
      if (last !== w.last)
        report($sformatf("idx %0d slot %0d last_word %0b", w.idx, w.slot, last));
    endtask
  endclass

endpackage

>>> tb/sv/tb_top.sv
// top-level bench for rainbow_hue_led_encoder_unit: directed and random led requests
// over several register settings, checked word by word; needs rhle_pkg and rhle_tb_pkg
module tb_top;
  import rhle_pkg::*;
  import rhle_tb_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 32;
  localparam int PhaseItems  = 62;
  localparam int PhaseCount  = 6;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                push        = 1'b0;
  logic                full;
  logic                mode_i      = 1'b0;
  logic [IdxW-1:0]     led_index_i = '0;
  logic [ColorW-1:0]   rgb_color_i = '0;
  logic                empty;
  logic                pop         = 1'b0;
  logic [DutyW-1:0]    duty_o;
  logic [IdxW-1:0]     out_index_o;
  logic [SlotW-1:0]    bit_slot_o;
  logic                last_word_o;

  led_word_board board;
  int                  idle_cycles = 0;
  int                  burst_left  = 0;

  rainbow_hue_led_encoder_unit #(.LED_COUNT(LedCount)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .led_index_i (led_index_i),
    .rgb_color_i (rgb_color_i),
    .empty       (empty),
    .pop         (pop),
    .duty_o      (duty_o),
    .out_index_o (out_index_o),
    .bit_slot_o  (bit_slot_o),
    .last_word_o (last_word_o)
  );

  initial forever #6 clk_i = ~clk_i;

  // monitor and watchdog, sampling values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_request(mode_i, led_index_i, rgb_color_i);
      if (pop && !empty) board.check_word(duty_o, out_index_o, bit_slot_o, last_word_o);
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver stalls: pop follows one of four styles, picked at random
  initial begin
    int cyc;
    int style;
    cyc   = 0;
    style = 0;
    forever begin
      @(negedge clk_i);
      if (cyc % 100 == 0) style = $urandom_range(0, 3);
      case (style)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ((cyc % 11) < 7);
      endcase
      cyc++;
    end
  end

  task write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    board.write_reg(addr, data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task send_request(logic mode, logic [IdxW-1:0] idx, logic [ColorW-1:0] color);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
    end
    @(negedge clk_i);
    push        <= 1'b1;
    mode_i      <= mode;
    led_index_i <= idx;
    rgb_color_i <= color;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
  endtask

  // lets out-of-range requests still in flight clear before a register write
  task wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task directed_requests();
    send_request(ModeDirect, 8'd0, 24'h000000);
    send_request(ModeDirect, 8'd1, 24'hffffff);
    send_request(ModeDirect, 8'd79, 24'ha5c33c);
    send_request(ModeDirect, 8'd2, 24'h800001);
    send_request(ModeDirect, 8'd3, 24'h010080);
    send_request(ModeDirect, 8'd80, 24'hffffff);
    send_request(ModeRainbow, 8'd255, 24'h123456);
    send_request(ModeDirect, 8'd128, 24'h5a5a5a);
    send_request(ModeRainbow, 8'd80, 24'h000000);
    // at least one request per ramp of the wheel, both sides of the boundaries at 255, 1020 and 1275
    send_request(ModeRainbow, 8'd0, 24'h000000);
    send_request(ModeRainbow, 8'd13, 24'h000000);
    send_request(ModeRainbow, 8'd14, 24'h000000);
    send_request(ModeRainbow, 8'd27, 24'h000000);
    send_request(ModeRainbow, 8'd40, 24'h000000);
    send_request(ModeRainbow, 8'd53, 24'h000000);
    send_request(ModeRainbow, 8'd54, 24'h000000);
    send_request(ModeRainbow, 8'd66, 24'h000000);
    send_request(ModeRainbow, 8'd67, 24'h000000);
    send_request(ModeRainbow, 8'd79, 24'h000000);
    send_request(ModeRainbow, 8'd0, 24'hffffff);
    send_request(ModeRainbow, 8'd79, 24'hc0ffee);
    send_request(ModeDirect, 8'd79, 24'h00ff00);
    send_request(ModeRainbow, 8'd40, 24'hffffff);
  endtask

  task apply_setting(int phase);
    case (phase)
      0: begin
        write_reg(CfgOneDuty, 11'd1023);
        write_reg(CfgZeroDuty, 11'd0);
        write_reg(CfgHueStep, 11'd1529);
      end
      1: begin
        write_reg(CfgOneDuty, 11'd0);
        write_reg(CfgZeroDuty, 11'd1023);
        write_reg(CfgHueStep, 11'd0);
        write_reg(CfgSpare, 11'(($urandom)));
      end
      2: begin
        write_reg(CfgOneDuty, 11'($urandom_range(0, 1023)));
        write_reg(CfgZeroDuty, 11'($urandom_range(0, 1023)));
        write_reg(CfgHueStep, 11'd2047);
      end
      3: begin
        write_reg(CfgHueStep, 11'd1530);
        write_reg(CfgOneDuty, 11'($urandom_range(0, 2047)));
        write_reg(CfgZeroDuty, 11'($urandom_range(0, 2047)));
      end
      4: begin
        write_reg(CfgOneDuty, 11'd60);
        write_reg(CfgZeroDuty, 11'd30);
        write_reg(CfgHueStep, 11'd1);
      end
      default: begin
        write_reg(CfgZeroDuty, 11'($urandom_range(0, 1023)));
        write_reg(CfgOneDuty, 11'($urandom_range(0, 1023)));
        write_reg(CfgHueStep, 11'($urandom_range(0, 2047)));
      end
    endcase
  endtask

  task random_requests(int count);
    int           done;
    int           pick;
    int           stride;
    int           pos;
    logic [IdxW-1:0] idx;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // partial rainbow frame sweeping up to the last led
        stride = $urandom_range(3, 20);
        pos    = $urandom_range(0, stride - 1);
        while (pos < LedCount - 1) begin
          send_request(ModeRainbow, IdxW'(pos), ColorW'($urandom));
          pos += stride;
          done++;
        end
        send_request(ModeRainbow, IdxW'(LedCount - 1), ColorW'($urandom));
        done++;
      end else if (pick < 50) begin
        send_request(ModeRainbow, IdxW'($urandom_range(0, LedCount - 1)), ColorW'($urandom));
        done++;
      end else if (pick < 75) begin
        send_request(ModeDirect, IdxW'($urandom_range(0, LedCount - 1)), ColorW'($urandom));
        done++;
      end else if (pick < 85) begin
        send_request(1'($urandom), IdxW'($urandom_range(LedCount, 255)), ColorW'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: idx = 8'd0;
          1: idx = IdxW'(LedCount - 1);
          2: idx = IdxW'(LedCount);
          default: idx = 8'd255;
        endcase
        send_request(1'($urandom), idx, ColorW'($urandom));
        if (int'(idx) < LedCount) done++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    directed_requests();
    for (int p = 0; p < PhaseCount; p++) begin
      wait_idle();
      apply_setting(p);
      random_requests(PhaseItems);
    end
    wait_idle();
    if (board.pending.size() != 0)
      board.report($sformatf("%0d words never came", board.pending.size()));
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> rainbow_hue_led_encoder_unit.f
+incdir+design
design/rhle_pkg.sv
design/rhle_fifo.sv
design/rhle_front.sv
design/rhle_back.sv
design/rainbow_hue_led_encoder_unit.sv
tb/sv/rhle_tb_pkg.sv
tb/sv/tb_top.sv
